>>> rtl/implant_decay_pixel_correlator_macros.svh
// assertion macros for the implant/decay pixel correlator
`ifndef IMPLANT_DECAY_PIXEL_CORRELATOR_MACROS_SVH
`define IMPLANT_DECAY_PIXEL_CORRELATOR_MACROS_SVH
`ifndef SYNTH
`define IDPC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define IDPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define IDPC_ASSERT_IMPL(label, ante, cons)
`define IDPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/idpc_pkg.sv
// shared types, constants and helpers of the pixel correlator
`timescale 1ns / 1ps
`default_nettype none
package idpc_pkg;
	localparam int STRIPS = 40;
	localparam int NEIGHBOUR_RADIUS = 1;
	localparam int PIXELS = STRIPS * STRIPS;
	localparam int ADDR_W = $clog2(PIXELS);
	localparam int SPAN = 2 * NEIGHBOUR_RADIUS + 1;
	localparam int OFS_W = $clog2(SPAN + 1);

	localparam logic [3:0] FLAG_NONE      = 4'd0;
	localparam logic [3:0] FLAG_BAD_PIXEL = 4'd1;
	localparam logic [3:0] FLAG_IMPLANT   = 4'd2;
	localparam logic [3:0] FLAG_DECAY     = 4'd3;
	localparam logic [3:0] FLAG_UNKNOWN   = 4'd4;
	localparam logic [3:0] FLAG_FRONT     = 4'd5;
	localparam logic [3:0] FLAG_BACK      = 4'd6;
	localparam logic [3:0] FLAG_REPEAT    = 4'd7;
	localparam logic [3:0] FLAG_BAD_IMP_T = 4'd8;
	localparam logic [3:0] FLAG_BAD_DEC_T = 4'd9;
	localparam logic [3:0] FLAG_SHORT_GAP = 4'd10;
	localparam logic [3:0] FLAG_CLEARED   = 4'd11;
	localparam logic [3:0] FLAG_PUNCH     = 4'd12;

	localparam logic REG_WINDOW  = 1'b0;
	localparam logic REG_MIN_GAP = 1'b1;

	typedef struct packed {
		logic               marked;
		logic [47:0]        tstamp;
		logic signed [48:0] gap;
		logic [63:0]        payload;
	} entry_t;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic imp_rd;
		logic imp_wr;
		logic scan_step;
		logic finish;
	} ctrl_t;

	typedef struct packed {
		logic clr_req;
		logic clr_last;
		logic imp_go;
		logic dec_go;
		logic scan_last;
	} status_t;

	function automatic logic [ADDR_W-1:0] pix_addr(input logic [6:0] f, input logic [6:0] b);
		logic [ADDR_W-1:0] fa;
		logic [ADDR_W-1:0] ba;
		fa = ADDR_W'(f) - ADDR_W'(1);
		ba = ADDR_W'(b) - ADDR_W'(1);
		return ADDR_W'(ba * ADDR_W'(STRIPS)) + fa;
	endfunction
endpackage
`default_nettype wire

>>> rtl/idpc_ctrl.sv
// sequencer: clearing pass, implant read-modify-write and neighbourhood scan
`timescale 1ns / 1ps
`default_nettype none
`include "implant_decay_pixel_correlator_macros.svh"
module idpc_ctrl import idpc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire status_t stat,
	output ctrl_t        ctrl
);
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_CLEAR    = 3'd1;
	localparam logic [2:0] ST_DISPATCH = 3'd2;
	localparam logic [2:0] ST_IMP_RD   = 3'd3;
	localparam logic [2:0] ST_IMP_WR   = 3'd4;
	localparam logic [2:0] ST_SCAN     = 3'd5;
	localparam logic [2:0] ST_SCAN_END = 3'd6;
	localparam logic [2:0] ST_RESULT   = 3'd7;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_CLEAR: begin
				ctrl.clr_step = 1'b1;
				// the sweep after reset has no item to hand on
				if (stat.clr_last) state_d = stat.clr_req ? ST_DISPATCH : ST_IDLE;
			end
			ST_DISPATCH: begin
				if (stat.clr_req) state_d = ST_CLEAR;
				else if (stat.imp_go) state_d = ST_IMP_RD;
				else if (stat.dec_go) state_d = ST_SCAN;
				else state_d = ST_RESULT;
			end
			ST_IMP_RD: begin
				ctrl.imp_rd = 1'b1;
				state_d = ST_IMP_WR;
			end
			ST_IMP_WR: begin
				ctrl.imp_wr = 1'b1;
				state_d = ST_RESULT;
			end
			ST_SCAN: begin
				ctrl.scan_step = 1'b1;
				if (stat.scan_last) state_d = ST_SCAN_END;
			end
			ST_SCAN_END: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				ctrl.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// reset enters the clearing pass; clr_req drops once the sweep has run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);

	`IDPC_ASSERT_NEXT(a_finish_idle, ctrl.finish, state_q == ST_IDLE)
	`IDPC_ASSERT_NEXT(a_load_busy, ctrl.load, busy)
	`IDPC_ASSERT_NEXT(a_wr_after_rd, ctrl.imp_rd, ctrl.imp_wr)
	`IDPC_ASSERT_IMPL(a_one_mem_op, ctrl.clr_step, !ctrl.imp_wr && !ctrl.scan_step)
endmodule
`default_nettype wire

>>> rtl/idpc_datapath.sv
// pixel map memory, event registers, match accumulation and result registers
`timescale 1ns / 1ps
`default_nettype none
module idpc_datapath import idpc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctrl_t       ctrl,
	output status_t          stat,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [47:0] cfg_data,
	input  wire logic        clear_request,
	input  wire logic [8:0]  hit_mask,
	input  wire logic [6:0]  implant_front_strip,
	input  wire logic [6:0]  implant_back_strip,
	input  wire logic [6:0]  decay_front_strip,
	input  wire logic [6:0]  decay_back_strip,
	input  wire logic [47:0] event_time,
	input  wire logic        time_valid,
	input  wire logic [63:0] implant_data,
	input  wire logic        neutron_hit,
	output logic               done,
	output logic [3:0]         flag,
	output logic [6:0]         match_front,
	output logic [6:0]         match_back,
	output logic [3:0]         match_count,
	output logic signed [48:0] elapsed_time,
	output logic [47:0]        stored_time,
	output logic [63:0]        stored_data,
	output logic               neutron_out
);
	logic [47:0] window_q, min_gap_q;
	logic        clr_q, tvalid_q, neut_q;
	logic [8:0]  hm_q;
	logic [6:0]  ifront_q, iback_q, dfront_q, dback_q;
	logic [47:0] now_q;
	logic [63:0] data_q;

	entry_t mem [PIXELS];
	entry_t rd_s1;
	entry_t wdata;
	logic [ADDR_W-1:0] raddr, waddr, sweep_q, imp_addr;
	logic we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			min_gap_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_WINDOW) window_q <= cfg_data;
			if (cfg_index == REG_MIN_GAP) min_gap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			hm_q <= hit_mask;
			ifront_q <= implant_front_strip;
			iback_q <= implant_back_strip;
			dfront_q <= decay_front_strip;
			dback_q <= decay_back_strip;
			now_q <= event_time;
			tvalid_q <= time_valid;
			data_q <= implant_data;
			neut_q <= neutron_hit;
		end
	end

	// clear request of the event, held until its result is assembled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= 1'b0;
		else if (ctrl.load) clr_q <= clear_request;
		else if (ctrl.finish) clr_q <= 1'b0;
	end

	logic clr_pending_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_pending_q <= 1'b0;
		else if (ctrl.load) clr_pending_q <= clear_request;
		else if (ctrl.clr_step && stat.clr_last) clr_pending_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sweep_q <= '0;
		else if (ctrl.clr_step) begin
			if (sweep_q == ADDR_W'(PIXELS - 1)) sweep_q <= '0;
			else sweep_q <= sweep_q + ADDR_W'(1);
		end
	end

	// classification
	logic pin1, pin2, pin3, sssd, scint, flo, blo, fhi, bhi;
	logic punch, imp, dec, iok;
	assign {bhi, fhi, blo, flo, scint, sssd, pin3, pin2, pin1} = hm_q;
	assign punch = (pin3 && sssd) || scint;
	assign imp = pin1 && pin2 && blo && flo && !sssd;
	assign dec = !pin1 && !pin2 && fhi && bhi && !flo && !blo && !punch;
	assign iok = (ifront_q >= 7'd1) && (ifront_q <= 7'(STRIPS)) &&
		(iback_q >= 7'd1) && (iback_q <= 7'(STRIPS));
	assign imp_addr = pix_addr(ifront_q, iback_q);

	// neighbourhood walk, front outer and back inner
	logic [OFS_W-1:0] fo_q, bo_q;
	logic signed [8:0] cf, cb;
	logic cell_ok;
	assign cf = $signed({2'b00, dfront_q}) + $signed({{(9-OFS_W){1'b0}}, fo_q})
		- 9'(NEIGHBOUR_RADIUS);
	assign cb = $signed({2'b00, dback_q}) + $signed({{(9-OFS_W){1'b0}}, bo_q})
		- 9'(NEIGHBOUR_RADIUS);
	assign cell_ok = (cf >= 9'sd1) && (cf <= 9'(STRIPS)) &&
		(cb >= 9'sd1) && (cb <= 9'(STRIPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fo_q <= '0;
			bo_q <= '0;
		end else if (ctrl.load) begin
			fo_q <= '0;
			bo_q <= '0;
		end else if (ctrl.scan_step) begin
			if (bo_q == OFS_W'(SPAN - 1)) begin
				bo_q <= '0;
				fo_q <= fo_q + OFS_W'(1);
			end else begin
				bo_q <= bo_q + OFS_W'(1);
			end
		end
	end

	assign stat.clr_req = clr_pending_q;
	assign stat.clr_last = (sweep_q == ADDR_W'(PIXELS - 1));
	assign stat.imp_go = imp && iok;
	assign stat.dec_go = !imp && dec;
	assign stat.scan_last = (fo_q == OFS_W'(SPAN - 1)) && (bo_q == OFS_W'(SPAN - 1));

	// memory ports
	assign raddr = ctrl.imp_rd ? imp_addr : pix_addr(cf[6:0], cb[6:0]);

	logic signed [48:0] imp_d;
	entry_t imp_new;
	logic [3:0] imp_flag;
	assign imp_d = $signed({1'b0, now_q}) - $signed({1'b0, rd_s1.tstamp});

	always_comb begin
		imp_new.marked = 1'b1;
		imp_new.tstamp = tvalid_q ? now_q : rd_s1.tstamp;
		imp_new.gap = (rd_s1.marked && tvalid_q) ? imp_d : rd_s1.gap;
		imp_new.payload = data_q;
		imp_flag = FLAG_IMPLANT;
		if (rd_s1.marked) begin
			imp_flag = FLAG_REPEAT;
			if (tvalid_q && (rd_s1.tstamp > now_q)) imp_flag = FLAG_BAD_IMP_T;
		end
	end

	always_comb begin
		we = ctrl.clr_step || ctrl.imp_wr;
		waddr = ctrl.clr_step ? sweep_q : imp_addr;
		wdata = ctrl.clr_step ? '0 : imp_new;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_s1 <= mem[raddr];
	end

	// evaluation of the cell read in the previous cycle
	logic cell_vld_s1;
	logic [6:0] cf_s1, cb_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cell_vld_s1 <= 1'b0;
		else cell_vld_s1 <= ctrl.scan_step && cell_ok;
	end
	always_ff @(posedge clk) begin
		cf_s1 <= cf[6:0];
		cb_s1 <= cb[6:0];
	end

	logic hit;
	assign hit = cell_vld_s1 && rd_s1.marked && tvalid_q &&
		(imp_d < $signed({1'b0, window_q}));

	logic               found_q, late_q;
	logic [3:0]         cnt_q;
	logic [6:0]         bf_q, bb_q;
	logic signed [48:0] el_q, gap_q;
	logic [47:0]        t_q;
	logic [63:0]        p_q;
	logic [3:0]         iflag_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			found_q <= 1'b0;
			late_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctrl.imp_wr) begin
			iflag_q <= imp_flag;
			el_q <= imp_new.gap;
			t_q <= imp_new.tstamp;
			p_q <= imp_new.payload;
		end else if (hit) begin
			if (imp_d < 0) begin
				late_q <= 1'b1;
			end else begin
				found_q <= 1'b1;
				bf_q <= cf_s1;
				bb_q <= cb_s1;
				el_q <= imp_d;
				gap_q <= rd_s1.gap;
				t_q <= rd_s1.tstamp;
				p_q <= rd_s1.payload;
				if (cnt_q != 4'd15) cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	// result assembly
	logic gap_ok;
	assign gap_ok = (gap_q >= $signed({1'b0, min_gap_q})) || (gap_q == 49'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= ctrl.finish;
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			flag <= FLAG_NONE;
			match_front <= '0;
			match_back <= '0;
			match_count <= '0;
			elapsed_time <= '0;
			stored_time <= '0;
			stored_data <= '0;
			neutron_out <= 1'b0;
			if (imp) begin
				if (iok) begin
					flag <= iflag_q;
					match_front <= ifront_q;
					match_back <= iback_q;
					elapsed_time <= el_q;
					stored_time <= t_q;
					stored_data <= p_q;
				end else begin
					flag <= FLAG_BAD_PIXEL;
				end
			end else if (dec) begin
				match_count <= cnt_q;
				if (found_q) begin
					match_front <= bf_q;
					match_back <= bb_q;
					if (gap_ok) begin
						flag <= FLAG_DECAY;
						elapsed_time <= el_q;
						stored_time <= t_q;
						stored_data <= p_q;
						neutron_out <= neut_q;
					end else begin
						flag <= FLAG_SHORT_GAP;
					end
				end else if (late_q) begin
					flag <= FLAG_BAD_DEC_T;
				end
			end else if (punch) begin
				flag <= FLAG_PUNCH;
			end else if (fhi && !bhi) begin
				flag <= FLAG_FRONT;
			end else if (!fhi && bhi) begin
				flag <= FLAG_BACK;
			end else begin
				flag <= FLAG_UNKNOWN;
			end
			if (clr_q) flag <= FLAG_CLEARED;
		end
	end
endmodule
`default_nettype wire

>>> rtl/implant_decay_pixel_correlator.sv
// implant/decay pixel correlator top level
// implants read and write their pixel, decays walk their neighbourhood, others do neither
// one event at a time, busy drops in the done cycle; the decay cost is set
// by the single read port of the pixel map walking the 3x3 neighbourhood one cell a cycle
// a clear request adds a sweep of all 1600 entries, one entry a cycle, and a redispatch
// after reset a sweep of the map runs with busy high; config writes always taken
`timescale 1ns / 1ps
`default_nettype none
module implant_decay_pixel_correlator import idpc_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic          cfg_index,
	input  wire logic [47:0]   cfg_data,
	input  wire logic          clear_request,
	input  wire logic [8:0]    hit_mask,
	input  wire logic [6:0]    implant_front_strip,
	input  wire logic [6:0]    implant_back_strip,
	input  wire logic [6:0]    decay_front_strip,
	input  wire logic [6:0]    decay_back_strip,
	input  wire logic [47:0]   event_time,
	input  wire logic          time_valid,
	input  wire logic [63:0]   implant_data,
	input  wire logic          neutron_hit,
	output logic               done,
	output logic [3:0]         flag,
	output logic [6:0]         match_front,
	output logic [6:0]         match_back,
	output logic [3:0]         match_count,
	output logic signed [48:0] elapsed_time,
	output logic [47:0]        stored_time,
	output logic [63:0]        stored_data,
	output logic               neutron_out
);
	ctrl_t   ctrl;
	status_t stat;

	assign cfg_ready = 1'b1;

	idpc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	idpc_datapath u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.ctrl                (ctrl),
		.stat                (stat),
		.cfg_we              (cfg_valid && cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.clear_request       (clear_request),
		.hit_mask            (hit_mask),
		.implant_front_strip (implant_front_strip),
		.implant_back_strip  (implant_back_strip),
		.decay_front_strip   (decay_front_strip),
		.decay_back_strip    (decay_back_strip),
		.event_time          (event_time),
		.time_valid          (time_valid),
		.implant_data        (implant_data),
		.neutron_hit         (neutron_hit),
		.done                (done),
		.flag                (flag),
		.match_front         (match_front),
		.match_back          (match_back),
		.match_count         (match_count),
		.elapsed_time        (elapsed_time),
		.stored_time         (stored_time),
		.stored_data         (stored_data),
		.neutron_out         (neutron_out)
	);
endmodule
`default_nettype wire

>>> tb/implant_decay_pixel_correlator_tb.sv
// testbench of the implant/decay pixel correlator: directed and random events against a predictor
`timescale 1ns / 1ps
`default_nettype none
module implant_decay_pixel_correlator_tb;
	import idpc_pkg::*;

	localparam logic [8:0] MASK_IMPLANT = 9'h063;
	localparam logic [8:0] MASK_DECAY   = 9'h180;
	localparam logic [8:0] MASK_SCINT   = 9'h010;
	localparam logic [8:0] MASK_FRONT   = 9'h080;
	localparam logic [8:0] MASK_BACK    = 9'h100;
	localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;
	localparam int WATCHDOG_LIMIT = 12000;
	localparam int DRAIN_CYCLES = 30;

	typedef struct {
		logic        clr;
		logic [8:0]  mask;
		logic [6:0]  ifront;
		logic [6:0]  iback;
		logic [6:0]  dfront;
		logic [6:0]  dback;
		logic [47:0] tstamp;
		logic        tvalid;
		logic [63:0] payload;
		logic        neut;
	} event_t;

	typedef struct {
		logic [3:0]  flag;
		logic [6:0]  mf;
		logic [6:0]  mb;
		logic [3:0]  cnt;
		logic [48:0] elapsed;
		logic [47:0] tstored;
		logic [63:0] dstored;
		logic        nout;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [47:0] cfg_data;
	logic clear_request;
	logic [8:0] hit_mask;
	logic [6:0] implant_front_strip;
	logic [6:0] implant_back_strip;
	logic [6:0] decay_front_strip;
	logic [6:0] decay_back_strip;
	logic [47:0] event_time;
	logic time_valid;
	logic [63:0] implant_data;
	logic neutron_hit;
	logic done;
	logic [3:0] flag;
	logic [6:0] match_front;
	logic [6:0] match_back;
	logic [3:0] match_count;
	logic signed [48:0] elapsed_time;
	logic [47:0] stored_time;
	logic [63:0] stored_data;
	logic neutron_out;

	implant_decay_pixel_correlator u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .clear_request(clear_request), .hit_mask(hit_mask),
		.implant_front_strip(implant_front_strip), .implant_back_strip(implant_back_strip),
		.decay_front_strip(decay_front_strip), .decay_back_strip(decay_back_strip),
		.event_time(event_time), .time_valid(time_valid), .implant_data(implant_data),
		.neutron_hit(neutron_hit), .done(done), .flag(flag), .match_front(match_front),
		.match_back(match_back), .match_count(match_count), .elapsed_time(elapsed_time),
		.stored_time(stored_time), .stored_data(stored_data), .neutron_out(neutron_out)
	);

	// predictor copy of the pixel map and registers
	bit          map_marked[PIXELS];
	logic [47:0] map_time[PIXELS];
	longint      map_gap[PIXELS];
	logic [63:0] map_payload[PIXELS];
	logic [47:0] window_reg;
	logic [47:0] min_gap_reg;

	outcome_t pending_results[$];
	int errors = 0;
	int idle_cycles = 0;
	logic [47:0] time_base = 48'd1000;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit strip_in_range(int s);
		return s >= 1 && s <= STRIPS;
	endfunction

	function automatic void wipe_map();
		for (int i = 0; i < PIXELS; i++) begin
			map_marked[i] = 1'b0;
			map_time[i] = '0;
			map_gap[i] = 0;
			map_payload[i] = '0;
		end
	endfunction

	function automatic outcome_t correlate(event_t e);
		outcome_t r;
		bit pin1, pin2, pin3, sssd, scint, flo, blo, fhi, bhi;
		bit punch, imp, dec, found;
		int p, bf, bb;
		longint now, d;
		pin1 = e.mask[0]; pin2 = e.mask[1]; pin3 = e.mask[2]; sssd = e.mask[3];
		scint = e.mask[4]; flo = e.mask[5]; blo = e.mask[6]; fhi = e.mask[7];
		bhi = e.mask[8];
		r = '{FLAG_NONE, 7'd0, 7'd0, 4'd0, 49'd0, 48'd0, 64'd0, 1'b0};
		now = longint'({16'd0, e.tstamp});
		found = 1'b0;
		bf = 0;
		bb = 0;
		if (e.clr)
			wipe_map();
		punch = (pin3 && sssd) || scint;
		imp = pin1 && pin2 && blo && flo && !sssd;
		dec = !pin1 && !pin2 && fhi && bhi && !flo && !blo && !punch;
		if (imp) begin
			if (strip_in_range(e.ifront) && strip_in_range(e.iback)) begin
				p = (int'(e.iback) - 1) * STRIPS + int'(e.ifront) - 1;
				r.flag = FLAG_IMPLANT;
				if (map_marked[p]) begin
					r.flag = FLAG_REPEAT;
					if (e.tvalid) begin
						if (map_time[p] > e.tstamp)
							r.flag = FLAG_BAD_IMP_T;
						map_gap[p] = now - longint'({16'd0, map_time[p]});
					end
				end else begin
					map_marked[p] = 1'b1;
				end
				if (e.tvalid)
					map_time[p] = e.tstamp;
				map_payload[p] = e.payload;
				r.mf = e.ifront;
				r.mb = e.iback;
				r.elapsed = map_gap[p][48:0];
				r.tstored = map_time[p];
				r.dstored = map_payload[p];
			end else begin
				r.flag = FLAG_BAD_PIXEL;
			end
		end else if (dec) begin
			for (int f = int'(e.dfront) - NEIGHBOUR_RADIUS;
					f <= int'(e.dfront) + NEIGHBOUR_RADIUS; f++) begin
				for (int b = int'(e.dback) - NEIGHBOUR_RADIUS;
						b <= int'(e.dback) + NEIGHBOUR_RADIUS; b++) begin
					if (strip_in_range(f) && strip_in_range(b)) begin
						p = (b - 1) * STRIPS + f - 1;
						if (map_marked[p]) begin
							d = now - longint'({16'd0, map_time[p]});
							if (d < longint'({16'd0, window_reg}) && e.tvalid) begin
								if (map_time[p] > e.tstamp) begin
									r.flag = FLAG_BAD_DEC_T;
								end else begin
									found = 1'b1;
									bf = f;
									bb = b;
									if (r.cnt < 4'd15)
										r.cnt = r.cnt + 4'd1;
								end
							end
						end
					end
				end
			end
			if (found) begin
				p = (bb - 1) * STRIPS + bf - 1;
				r.mf = 7'(bf);
				r.mb = 7'(bb);
				if (map_gap[p] >= longint'({16'd0, min_gap_reg}) || map_gap[p] == 0) begin
					r.flag = FLAG_DECAY;
					d = now - longint'({16'd0, map_time[p]});
					r.elapsed = d[48:0];
					r.tstored = map_time[p];
					r.dstored = map_payload[p];
					r.nout = e.neut;
				end else begin
					r.flag = FLAG_SHORT_GAP;
				end
			end
		end else if (punch) begin
			r.flag = FLAG_PUNCH;
		end else begin
			r.flag = FLAG_UNKNOWN;
			if (fhi && !bhi)
				r.flag = FLAG_FRONT;
			if (!fhi && bhi)
				r.flag = FLAG_BACK;
		end
		if (e.clr)
			r.flag = FLAG_CLEARED;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		outcome_t x;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding, flag %0d", flag);
				errors++;
			end else begin
				x = pending_results.pop_front();
				if (flag !== x.flag) begin
					$error("flag expected %0d actual %0d", x.flag, flag); errors++;
				end
				if (match_front !== x.mf) begin
					$error("match_front expected %0d actual %0d", x.mf, match_front); errors++;
				end
				if (match_back !== x.mb) begin
					$error("match_back expected %0d actual %0d", x.mb, match_back); errors++;
				end
				if (match_count !== x.cnt) begin
					$error("match_count expected %0d actual %0d", x.cnt, match_count); errors++;
				end
				if (elapsed_time !== x.elapsed) begin
					$error("elapsed_time expected %h actual %h", x.elapsed, elapsed_time);
					errors++;
				end
				if (stored_time !== x.tstored) begin
					$error("stored_time expected %h actual %h", x.tstored, stored_time); errors++;
				end
				if (stored_data !== x.dstored) begin
					$error("stored_data expected %h actual %h", x.dstored, stored_data); errors++;
				end
				if (neutron_out !== x.nout) begin
					$error("neutron_out expected %0d actual %0d", x.nout, neutron_out); errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	task automatic send_item(event_t e, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		clear_request <= e.clr;
		hit_mask <= e.mask;
		implant_front_strip <= e.ifront;
		implant_back_strip <= e.iback;
		decay_front_strip <= e.dfront;
		decay_back_strip <= e.dback;
		event_time <= e.tstamp;
		time_valid <= e.tvalid;
		implant_data <= e.payload;
		neutron_hit <= e.neut;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(correlate(e));
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [47:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_WINDOW)
			window_reg = value;
		else
			min_gap_reg = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(logic [47:0] win, logic [47:0] gap);
		drain();
		write_reg(REG_WINDOW, win);
		write_reg(REG_MIN_GAP, gap);
	endtask

	function automatic event_t mk(logic [8:0] mask, int f, int b, logic [47:0] t, bit tv);
		event_t e;
		e.clr = 1'b0;
		e.mask = mask;
		e.ifront = 7'(f);
		e.iback = 7'(b);
		e.dfront = 7'(f);
		e.dback = 7'(b);
		e.tstamp = t;
		e.tvalid = tv;
		e.payload = {$urandom, $urandom};
		e.neut = 1'($urandom_range(0, 1));
		return e;
	endfunction

	task automatic test_classify();
		send_item(mk(9'h000, 3, 3, 48'd10, 1), pick_gap());
		send_item(mk(MASK_FRONT, 3, 3, 48'd10, 1), pick_gap());
		send_item(mk(MASK_BACK, 3, 3, 48'd10, 1), pick_gap());
		send_item(mk(MASK_SCINT, 3, 3, 48'd10, 1), pick_gap());
		send_item(mk(9'h00C | MASK_DECAY, 3, 3, 48'd10, 1), pick_gap());
		send_item(mk(9'h1FF, 3, 3, T_MAX, 1), pick_gap());
		send_item(mk(MASK_IMPLANT, 0, 5, 48'd10, 1), pick_gap());
		send_item(mk(MASK_IMPLANT, 41, 1, 48'd10, 1), pick_gap());
		send_item(mk(MASK_IMPLANT, 127, 127, 48'd10, 1), pick_gap());
	endtask

	task automatic test_implant_decay();
		event_t e;
		send_item(mk(MASK_IMPLANT, 1, 1, 48'd100, 1), pick_gap());
		send_item(mk(MASK_IMPLANT, 1, 1, 48'd150, 1), pick_gap());
		send_item(mk(MASK_IMPLANT, 1, 1, 48'd120, 1), pick_gap());
		send_item(mk(MASK_IMPLANT, 1, 1, 48'd900, 0), pick_gap());
		send_item(mk(MASK_IMPLANT, 2, 1, 48'd130, 1), pick_gap());
		send_item(mk(MASK_DECAY, 2, 2, 48'd400, 1), pick_gap());
		send_item(mk(MASK_DECAY, 0, 0, 48'd400, 1), pick_gap());
		send_item(mk(MASK_DECAY, 2, 2, 48'd400, 0), pick_gap());
		send_item(mk(MASK_DECAY, 1, 1, 48'd50, 1), pick_gap());
		send_item(mk(MASK_IMPLANT, 40, 40, T_MAX, 1), pick_gap());
		send_item(mk(MASK_DECAY, 41, 41, T_MAX, 1), pick_gap());
		e = mk(MASK_DECAY, 2, 2, 48'd500, 1);
		e.clr = 1'b1;
		send_item(e, pick_gap());
		send_item(mk(MASK_DECAY, 2, 2, 48'd510, 1), pick_gap());
	endtask

	task automatic test_short_gap();
		send_item(mk(MASK_IMPLANT, 10, 10, 48'd1000, 1), pick_gap());
		send_item(mk(MASK_IMPLANT, 10, 10, 48'd1005, 1), pick_gap());
		send_item(mk(MASK_DECAY, 10, 11, 48'd1010, 1), pick_gap());
		send_item(mk(MASK_IMPLANT, 10, 10, 48'd2000, 1), pick_gap());
		send_item(mk(MASK_DECAY, 9, 9, 48'd2010, 1), pick_gap());
	endtask

	function automatic int pick_strip();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(4, 7);
		if (r < 90)
			return ($urandom_range(0, 1) != 0) ? 1 : STRIPS;
		return $urandom_range(0, 127);
	endfunction

	task automatic test_random(int count);
		event_t e;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			time_base = time_base + 48'($urandom_range(0, 150));
			if (r < 40)
				e = mk(MASK_IMPLANT, pick_strip(), pick_strip(), time_base, 1);
			else if (r < 80)
				e = mk(MASK_DECAY, pick_strip(), pick_strip(), time_base, 1);
			else
				e = mk(9'($urandom), $urandom_range(0, 127), $urandom_range(0, 127),
					48'({$urandom, $urandom}), 1);
			e.ifront = 7'(pick_strip());
			e.iback = 7'(pick_strip());
			if ($urandom_range(0, 19) == 0)
				e.tstamp = 48'({$urandom, $urandom});
			else if ($urandom_range(0, 9) == 0)
				e.tstamp = time_base - 48'($urandom_range(0, 400));
			e.tvalid = ($urandom_range(0, 9) != 0);
			e.clr = ($urandom_range(0, 59) == 0);
			send_item(e, pick_gap());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_WINDOW;
		cfg_data <= '0;
		clear_request <= 1'b0;
		hit_mask <= '0;
		implant_front_strip <= '0;
		implant_back_strip <= '0;
		decay_front_strip <= '0;
		decay_back_strip <= '0;
		event_time <= '0;
		time_valid <= 1'b0;
		implant_data <= '0;
		neutron_hit <= 1'b0;
		wipe_map();
		window_reg = '0;
		min_gap_reg = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_random(40);
		set_regs(48'd1000, 48'd0);
		test_classify();
		test_implant_decay();
		set_regs(48'd1000, 48'd100);
		test_short_gap();
		test_random(120);
		set_regs(T_MAX, T_MAX);
		test_random(90);
		set_regs(48'd300, 48'd40);
		test_random(120);
		set_regs(48'd1, 48'd0);
		test_random(50);

		drain();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
